FILE: src/arts_pkg.sv
// Shared types and constants for the audio reframer / timestamper.
// No dependencies; imported by arts_divider and audio_reframer_timestamper_core.
`timescale 1ns / 1ps
`default_nettype none

package arts_pkg;

    // Field and arithmetic widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 64;
    localparam int RATE_W   = 19;
    localparam int LEN_W    = 11;
    localparam int POS_W    = 10;
    // Numerator of the timestamp step: out_len * 1e6 + remainder stays below 2^30
    localparam int NUM_W    = 30;
    localparam int PROD_W   = 31;

    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = 11'd1024;
    localparam logic [19:0]      US_PER_SEC    = 20'd1000000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_FRAME_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_FRAME_LEN = 2'd2;

    // Input item
    typedef struct packed {
        logic        [SAMPLE_W-1:0] sample_in;
        logic signed [TIME_W-1:0]   frame_time_in;
    } t_in;

    // Result item
    typedef struct packed {
        logic        [SAMPLE_W-1:0] sample_out;
        logic signed [TIME_W-1:0]   out_frame_time;
        logic                       out_first;
        logic                       out_last;
    } t_out;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [RATE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quot;
        logic [RATE_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: src/arts_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, for the timestamp step.
// Depends on arts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arts_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire arts_pkg::t_div_req i_req,
    output arts_pkg::t_div_rsp     o_rsp
);
    import arts_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_quo;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_dvs;

    logic [RATE_W:0]   w_trial;
    logic              w_ge;
    logic [RATE_W-1:0] n_rem;

    // Shift in the next numerator bit and try one subtraction
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        if (w_ge) begin
            n_rem = RATE_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[RATE_W-1:0];
        end
    end

    // Control: load on start, step while busy, pulse done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    // Datapath: numerator register turns into the quotient bit by bit
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.numer;
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: src/audio_reframer_timestamper_core.sv
// Audio reframer with microsecond timestamps: top level, config registers, sequencer.
// Depends on arts_pkg and arts_divider.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted sample comes back as one result item: the same sample, the
// timestamp of its output frame and first/last marks. After a sample that does not
// close an output frame, the next sample may follow in the next cycle once the
// output register is free or being drained. A sample that closes an output
// frame while sample_rate is nonzero keeps the input channel blocked while
// the S_MUL state starts the divider on out_frame_len * 1e6 plus the carried
// remainder, the bit-serial divider produces the timestamp step in S_DIV, and
// the step is added to the timestamp as the divider reports done. Its result item
// is presented right away; only the next input waits on the divider.
// Configuration writes take effect at once and are meant for idle periods.
module audio_reframer_timestamper_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [arts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [arts_pkg::RATE_W-1:0]  i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire arts_pkg::t_in                i_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output arts_pkg::t_out                    o_out
);
    import arts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // Configuration and state registers
    logic [RATE_W-1:0] r_rate;
    logic [LEN_W-1:0]  r_in_len;
    logic [LEN_W-1:0]  r_out_len;
    logic [TIME_W-1:0] r_time_now;
    logic [RATE_W-1:0] r_time_rem;
    logic [POS_W-1:0]  r_in_pos;
    logic [POS_W-1:0]  r_out_pos;
    logic [1:0]        r_state;
    logic [NUM_W-1:0]  r_prod;
    logic [RATE_W-1:0] r_div_rate;
    logic              r_out_valid;
    t_out              r_out;

    logic [LEN_W-1:0]  w_in_len;
    logic [LEN_W-1:0]  w_out_len;
    logic              w_in_acc;
    logic              w_first;
    logic              w_last;
    logic              w_load;
    logic              w_in_wrap;
    logic [TIME_W-1:0] w_time;
    logic [PROD_W-1:0] w_prod;
    logic [NUM_W-1:0]  w_step;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    // Treat a zero length as one and saturate at the maximum frame length
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > MAX_FRAME_LEN) begin
            res = MAX_FRAME_LEN;
        end else begin
            res = len;
        end
        return res;
    endfunction

    assign w_in_len  = clamp_len(r_in_len);
    assign w_out_len = clamp_len(r_out_len);

    // Frame position decode for the incoming item
    assign w_first   = (r_out_pos == '0);
    assign w_load    = w_first && (r_in_pos == '0);
    assign w_last    = (({1'b0, r_out_pos} + LEN_W'(1)) >= w_out_len);
    assign w_in_wrap = (({1'b0, r_in_pos} + LEN_W'(1)) >= w_in_len);
    assign w_time    = w_load ? i_in.frame_time_in : r_time_now;
    assign w_prod    = PROD_W'(w_out_len) * PROD_W'(US_PER_SEC);

    // Accept only between frame-end divisions and with the output slot free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RATE_W'(16000);
            r_in_len  <= LEN_W'(160);
            r_out_len <= LEN_W'(1024);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_RATE:   r_rate    <= i_cfg_data;
                CFG_IN_FRAME_LEN:  r_in_len  <= i_cfg_data[LEN_W-1:0];
                CFG_OUT_FRAME_LEN: r_out_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider request: numerator formed from the latched product and remainder
    assign w_div_req.start   = (r_state == S_MUL);
    assign w_div_req.numer   = r_prod + NUM_W'(r_time_rem);
    assign w_div_req.divisor = r_div_rate;

    arts_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // Force the step to at least one microsecond
    assign w_step = (w_div_rsp.quot == '0) ? NUM_W'(1) : w_div_rsp.quot;

    // Sequencer, positions and timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_time_now <= '0;
            r_time_rem <= '0;
            r_in_pos   <= '0;
            r_out_pos  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_load) begin
                            r_time_now <= i_in.frame_time_in;
                            r_time_rem <= '0;
                        end
                        r_in_pos <= w_in_wrap ? '0 : r_in_pos + POS_W'(1);
                        if (w_last) begin
                            r_out_pos <= '0;
                            if (r_rate != '0) begin
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_out_pos <= r_out_pos + POS_W'(1);
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_time_now <= r_time_now + TIME_W'(w_step);
                        r_time_rem <= w_div_rsp.rem;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Latch the product and divisor with the frame-closing item
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_last) begin
            r_prod     <= w_prod[NUM_W-1:0];
            r_div_rate <= r_rate;
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out.sample_out     <= i_in.sample_in;
            r_out.out_frame_time <= w_time;
            r_out.out_first      <= w_first;
            r_out.out_last       <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // A frame-closing item with a nonzero rate starts the step computation
    a_frame_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last && (r_rate != '0)) |=> (r_state == S_MUL))
        else $error("frame end did not start the timestamp step");

    // The divider reports completion only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside of the wait state");

    // The timestamp holds while the divider runs
    a_time_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && !w_div_rsp.done) |=> $stable(r_time_now))
        else $error("timestamp moved during division");

    // A loading item reports the input timestamp
    a_load_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_load) |=> (r_out.out_frame_time == $past(i_in.frame_time_in)))
        else $error("loaded timestamp not reported");
`endif

endmodule

`default_nettype wire
